// ----- hdl/rasc_pkg.sv -----
`timescale 1ns / 1ps

package rasc_pkg;

  localparam int CELL_W         = 64;
  localparam int RULE_W         = 64;
  localparam int RULE_IDX_W     = 6;
  localparam int LEN_REG_W      = 7;
  localparam int WIN_REG_W      = 3;
  localparam int GEN_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int MAX_CELLS_DEF  = 64;
  localparam int MAX_WINDOW_DEF = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RULE_TABLE   = 3'd0,
    REG_RING_LENGTH  = 3'd1,
    REG_NEIGHBORHOOD = 3'd2,
    REG_GENERATIONS  = 3'd3,
    REG_MASK_BEFORE  = 3'd4,
    REG_MASK_AFTER   = 3'd5,
    REG_INVERT_FLAG  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [CELL_W-1:0] start_state;
    logic              sweep_last;
  } in_t;

  typedef struct packed {
    logic [CELL_W-1:0] end_state;
    logic              holds_direct;
    logic              holds_inverted;
    logic              sweep_match;
    logic              sweep_needs_invert;
    logic              result_last;
  } out_t;

endpackage

// ----- hdl/ring_automaton_spec_checker_core.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                        Moves
// in        input      in_valid, in_ready, in_data    one start state request
// out       output     out_valid, out_ready, out_data one result
// cfg       input      cfg_write, cfg_index, cfg_data register write, no wait
//
// A request is taken in the idle state, then the ring takes one step per generation
// and the result is formed, before the next request can be accepted.
// The generation unit computes every cell of the ring together, combinationally.
// The result sits in an output register, so a new request is taken while it waits.
// Reset is synchronous and restores every configuration register to its default.
// A stall on the output only holds the block in its result state.

module ring_automaton_spec_checker_core #(
  parameter int MAX_CELLS  = rasc_pkg::MAX_CELLS_DEF,
  parameter int MAX_WINDOW = rasc_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  rasc_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rasc_pkg::out_t                 out_data,
  input  logic                           cfg_write,
  input  logic [rasc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rasc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rasc_pkg::*;

  localparam int LEN_W = $clog2(MAX_CELLS + 1);
  localparam int WIN_W = $clog2(MAX_WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_STEP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                state;
  logic [RULE_W-1:0]     rule_table;
  logic [LEN_REG_W-1:0]  ring_length;
  logic [WIN_REG_W-1:0]  neighborhood;
  logic [GEN_W-1:0]      generations;
  logic [CELL_W-1:0]     mask_before;
  logic [CELL_W-1:0]     mask_after;
  logic                  invert_flag;

  logic                  all_direct_ok;
  logic                  all_inverted_ok;
  logic [CELL_W-1:0]     working_cells;
  logic [GEN_W-1:0]      generation_count;
  logic                  parity_pre;
  logic                  item_last;

  logic [LEN_W-1:0]      len_eff;
  logic [WIN_W-1:0]      win_eff;
  logic [CELL_W-1:0]     cells_next;
  logic                  parity_post;
  logic                  direct;
  logic                  inverted;
  logic                  direct_acc;
  logic                  inverted_acc;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    if (ring_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (ring_length > LEN_REG_W'(MAX_CELLS)) begin
      len_eff = LEN_W'(MAX_CELLS);
    end else begin
      len_eff = LEN_W'(ring_length);
    end
    if (neighborhood == '0) begin
      win_eff = WIN_W'(1);
    end else if (neighborhood > WIN_REG_W'(MAX_WINDOW)) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = WIN_W'(neighborhood);
    end
  end

  // Each rotated copy moves the ring one cell further, wrapping at the ring length.
  always_comb begin
    logic [MAX_CELLS-1:0]  rot [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] win_bits;
    logic [RULE_IDX_W-1:0] rule_idx;
    rot[0] = working_cells[MAX_CELLS-1:0];
    for (int j = 1; j < MAX_WINDOW; j++) begin
      for (int i = 0; i < MAX_CELLS; i++) begin
        if (LEN_W'(i + 1) == len_eff) begin
          rot[j][i] = rot[j-1][0];
        end else if (i < MAX_CELLS - 1) begin
          rot[j][i] = rot[j-1][i+1];
        end else begin
          rot[j][i] = 1'b0;
        end
      end
    end
    cells_next = '0;
    for (int i = 0; i < MAX_CELLS; i++) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        win_bits[MAX_WINDOW-1-j] = rot[j][i];
      end
      rule_idx = RULE_IDX_W'(win_bits >> (WIN_W'(MAX_WINDOW) - win_eff));
      if (LEN_W'(i) < len_eff) begin
        cells_next[i] = rule_table[rule_idx];
      end
    end
  end

  assign parity_post  = ^(mask_after & working_cells);
  assign direct       = ((parity_pre ^ invert_flag) == parity_post);
  assign inverted     = ~direct;
  assign direct_acc   = all_direct_ok & direct;
  assign inverted_acc = all_inverted_ok & inverted;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      rule_table       <= '0;
      ring_length      <= LEN_REG_W'(64);
      neighborhood     <= WIN_REG_W'(3);
      generations      <= GEN_W'(1);
      mask_before      <= '0;
      mask_after       <= '0;
      invert_flag      <= 1'b0;
      all_direct_ok    <= 1'b1;
      all_inverted_ok  <= 1'b1;
      working_cells    <= '0;
      generation_count <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_RULE_TABLE:   rule_table   <= cfg_data[RULE_W-1:0];
          REG_RING_LENGTH:  ring_length  <= cfg_data[LEN_REG_W-1:0];
          REG_NEIGHBORHOOD: neighborhood <= cfg_data[WIN_REG_W-1:0];
          REG_GENERATIONS:  generations  <= cfg_data[GEN_W-1:0];
          REG_MASK_BEFORE:  mask_before  <= cfg_data[CELL_W-1:0];
          REG_MASK_AFTER:   mask_after   <= cfg_data[CELL_W-1:0];
          REG_INVERT_FLAG:  invert_flag  <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            working_cells    <= in_data.start_state;
            parity_pre       <= ^(mask_before & in_data.start_state);
            item_last        <= in_data.sweep_last;
            generation_count <= generations;
            state            <= (generations == '0) ? ST_EMIT : ST_STEP;
          end
        end
        ST_STEP: begin
          working_cells    <= cells_next;
          generation_count <= generation_count - GEN_W'(1);
          if (generation_count == GEN_W'(1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid                   <= 1'b1;
            out_data.end_state          <= working_cells;
            out_data.holds_direct       <= direct;
            out_data.holds_inverted     <= inverted;
            out_data.sweep_match        <= item_last & (direct_acc | inverted_acc);
            out_data.sweep_needs_invert <= item_last & ~direct_acc;
            out_data.result_last        <= item_last;
            all_direct_ok               <= item_last | direct_acc;
            all_inverted_ok             <= item_last | inverted_acc;
            state                       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    state == ST_STEP |-> generation_count != '0)
    else $error("generation unit running with no generation left");

  a_zero_gen_skips: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid && generations == '0) |=> state == ST_EMIT)
    else $error("request with zero generations did not go straight to result");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_EMIT))
    else $error("result appeared outside the result cycle");

  a_sweep_fields_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.result_last) |->
      (!out_data.sweep_match && !out_data.sweep_needs_invert))
    else $error("sweep fields set on a result that ends no sweep");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rasc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_REQUESTS = 600;

  class ring_result_board;
    logic [RULE_W-1:0]    rule;
    logic [LEN_REG_W-1:0] len_reg;
    logic [WIN_REG_W-1:0] win_reg;
    logic [GEN_W-1:0]     gen_reg;
    logic [CELL_W-1:0]    before_mask;
    logic [CELL_W-1:0]    after_mask;
    logic                 inv;
    bit                   direct_ok;
    bit                   inverted_ok;
    out_t                 pending_results[$];
    int                   errors;
    int                   requests;
    int                   results;
    int                   sweep_ends;
    int                   sweep_hits;

    function new();
      rule        = '0;
      len_reg     = 7'd64;
      win_reg     = 3'd3;
      gen_reg     = 16'd1;
      before_mask = '0;
      after_mask  = '0;
      inv         = 1'b0;
      direct_ok   = 1'b1;
      inverted_ok = 1'b1;
      errors      = 0;
      requests    = 0;
      results     = 0;
      sweep_ends  = 0;
      sweep_hits  = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_RULE_TABLE:   rule = val;
        REG_RING_LENGTH:  len_reg = val[LEN_REG_W-1:0];
        REG_NEIGHBORHOOD: win_reg = val[WIN_REG_W-1:0];
        REG_GENERATIONS:  gen_reg = val[GEN_W-1:0];
        REG_MASK_BEFORE:  before_mask = val;
        REG_MASK_AFTER:   after_mask = val;
        REG_INVERT_FLAG:  inv = val[0];
        default: ;
      endcase
    endfunction

    function logic [CELL_W-1:0] advance_ring(logic [CELL_W-1:0] cells, int n, int w);
      logic [CELL_W-1:0]     nxt;
      logic [RULE_IDX_W-1:0] pat;
      int                    pos;
      nxt = '0;
      for (int i = 0; i < n; i++) begin
        pat = '0;
        pos = i;
        for (int j = 0; j < w; j++) begin
          pat = {pat[RULE_IDX_W-2:0], cells[pos]};
          pos++;
          if (pos >= n) pos = 0;
        end
        nxt[i] = rule[pat];
      end
      return nxt;
    endfunction

    function void note_request(in_t req);
      logic [CELL_W-1:0] cells;
      int                n;
      int                w;
      bit                p_pre;
      bit                p_post;
      bit                held;
      bit                held_inv;
      out_t              want;
      n = (len_reg == 0) ? 1 : ((len_reg > MAX_CELLS_DEF) ? MAX_CELLS_DEF : int'(len_reg));
      w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(win_reg));
      cells = req.start_state;
      for (int g = 0; g < int'(gen_reg); g++) cells = advance_ring(cells, n, w);
      p_pre    = ^(before_mask & req.start_state);
      p_post   = ^(after_mask & cells);
      held     = ((p_pre ^ inv) == p_post);
      held_inv = ((p_pre ^ inv ^ 1'b1) == p_post);
      direct_ok   = direct_ok && held;
      inverted_ok = inverted_ok && held_inv;
      want = '0;
      want.end_state      = cells;
      want.holds_direct   = held;
      want.holds_inverted = held_inv;
      want.result_last    = req.sweep_last;
      if (req.sweep_last) begin
        want.sweep_match        = direct_ok || inverted_ok;
        want.sweep_needs_invert = !direct_ok;
        sweep_ends++;
        if (want.sweep_match) sweep_hits++;
        direct_ok   = 1'b1;
        inverted_ok = 1'b1;
      end
      pending_results.push_back(want);
      requests++;
    endfunction

    task report(string what, logic [CELL_W-1:0] got_v, logic [CELL_W-1:0] want_v);
      $display("MISMATCH %s at result %0d: got %h, expected %h", what, results, got_v, want_v);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report("result with no request waiting", got.end_state, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.end_state !== want.end_state)
          report("end_state", got.end_state, want.end_state);
        if (got.holds_direct !== want.holds_direct)
          report("holds_direct", CELL_W'(got.holds_direct), CELL_W'(want.holds_direct));
        if (got.holds_inverted !== want.holds_inverted)
          report("holds_inverted", CELL_W'(got.holds_inverted),
                 CELL_W'(want.holds_inverted));
        if (got.sweep_match !== want.sweep_match)
          report("sweep_match", CELL_W'(got.sweep_match), CELL_W'(want.sweep_match));
        if (got.sweep_needs_invert !== want.sweep_needs_invert)
          report("sweep_needs_invert", CELL_W'(got.sweep_needs_invert),
                 CELL_W'(want.sweep_needs_invert));
        if (got.result_last !== want.result_last)
          report("result_last", CELL_W'(got.result_last), CELL_W'(want.result_last));
      end
      results++;
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ring_result_board sb;
  int  cycles = 0;
  int  burst_left = 0;
  bit  tx_gaps = 1'b0;
  bit  rx_eager = 1'b1;
  int  rx_run = 0;
  bit  rx_level = 1'b1;
  int  settings_count = 0;

  ring_automaton_spec_checker_core u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ring_automaton_spec_checker_core test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_run == 0) begin
        rx_level = rx_eager || ($urandom_range(0, 2) != 0);
        rx_run   = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 7);
      end
      out_ready <= rx_level;
      rx_run--;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    sb.apply_write(idx, val);
  endtask

  task automatic program_regs(input logic [63:0] rule_v, input logic [6:0] len_v,
                              input logic [2:0] win_v, input logic [15:0] gen_v,
                              input logic [63:0] mb, input logic [63:0] ma,
                              input logic inv_v);
    write_reg(REG_RULE_TABLE, rule_v);
    write_reg(REG_RING_LENGTH, {57'd0, len_v});
    write_reg(REG_NEIGHBORHOOD, {61'd0, win_v});
    write_reg(REG_GENERATIONS, {48'd0, gen_v});
    write_reg(REG_MASK_BEFORE, mb);
    write_reg(REG_MASK_AFTER, ma);
    write_reg(REG_INVERT_FLAG, {63'd0, inv_v});
    cfg_write <= 1'b0;
    settings_count++;
  endtask

  task automatic send_request(input logic [63:0] st, input logic lst);
    in_t req;
    req.start_state = st;
    req.sweep_last  = lst;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (tx_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Holds the sender back until every outstanding request has produced its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int          n;
    logic [6:0]  len_v;
    logic [15:0] gen_v;
    logic [63:0] mb;
    logic [63:0] ma;
    sb        = new();
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_request(64'h0, 1'b0);
    send_request('1, 1'b1);

    settle();
    program_regs(64'h6E, 7'd64, 3'd3, 16'd1, '1, '1, 1'b0);
    send_request(64'h1, 1'b0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_request(64'h5555_5555_5555_5555, 1'b0);
    send_request('1, 1'b1);

    // With no generations and equal masks, only the inverted check can hold.
    settle();
    mb = {$urandom, $urandom};
    program_regs({$urandom, $urandom}, 7'd10, 3'd2, 16'd0, mb, mb, 1'b1);
    send_request({$urandom, $urandom}, 1'b0);
    send_request('1, 1'b0);
    send_request(64'h8000_0000_0000_0001, 1'b1);

    settle();
    program_regs({$urandom, $urandom}, 7'd0, 3'd0, 16'd3, {$urandom, $urandom},
                 {$urandom, $urandom}, 1'b0);
    @(negedge clk);
    write_reg(REG_UNUSED, '1);
    cfg_write <= 1'b0;
    send_request({$urandom, $urandom}, 1'b0);
    send_request('1, 1'b1);
    send_request(64'h0, 1'b1);

    settle();
    program_regs({$urandom, $urandom}, 7'd127, 3'd7, 16'd2, {$urandom, $urandom},
                 {$urandom, $urandom}, 1'b0);
    send_request({$urandom, $urandom}, 1'b0);
    send_request({$urandom, $urandom}, 1'b0);
    send_request({$urandom, $urandom}, 1'b1);

    settle();
    program_regs('1, 7'd2, 3'd6, 16'd1, '1, 64'h3, 1'b1);
    send_request(64'h2, 1'b0);
    send_request({$urandom, $urandom}, 1'b1);

    settle();
    program_regs(64'h6E, 7'd5, 3'd3, 16'hFFFF, 64'h1F, 64'h1F, 1'b0);
    send_request(64'h0000_0000_0000_0013, 1'b1);

    tx_gaps = 1'b1;
    while (sb.requests < RANDOM_REQUESTS + 18) begin
      settle();
      case ($urandom_range(0, 9))
        0:       len_v = 7'd0;
        1:       len_v = 7'($urandom_range(65, 127));
        2:       len_v = 7'd64;
        3:       len_v = 7'd1;
        4:       len_v = 7'd2;
        default: len_v = 7'($urandom_range(1, 64));
      endcase
      gen_v = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                : $urandom_range(0, 6));
      mb = ($urandom_range(0, 3) == 0) ? 64'h0 : rand_word();
      ma = ($urandom_range(0, 3) == 0) ? mb : rand_word();
      program_regs(rand_word(), len_v, 3'($urandom_range(0, 7)), gen_v, mb, ma,
                   1'($urandom_range(0, 1)));
      tx_gaps  = ($urandom_range(0, 3) != 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 50);
      for (int k = 0; k < n; k++) begin
        if (settings_count % 4 == 1 && k == n / 2) settle();
        send_request(rand_word(), (k == n - 1) || ($urandom_range(0, 4) == 0));
      end
    end

    settle();
    repeat (64) @(negedge clk);
    if (sb.pending_results.size() != 0)
      sb.report("results never delivered", CELL_W'(sb.pending_results.size()), '0);
    $display("Covered %0d requests under %0d register settings, %0d sweep ends (%0d matched).",
             sb.requests, settings_count, sb.sweep_ends, sb.sweep_hits);
    $display("Ring lengths 0 to 127, windows 0 to 7 and up to 65535 generations were used.");
    if (sb.errors == 0) begin
      $display("ring_automaton_spec_checker_core test passed");
    end else begin
      $display("ring_automaton_spec_checker_core test failed");
    end
    $finish;
  end

endmodule
